[hdl/ttdc_pkg.sv]
// ttdc_pkg: types and constants of the target tracking drive controller
// shared by the front, queue, back and top level; depends on nothing
`timescale 1ns / 1ps

package ttdc_pkg;

    // drive modes
    typedef enum logic [1:0]
    {
        MODE_RUN    = 2'd0,
        MODE_SEEK_L = 2'd1,
        MODE_SEEK_R = 2'd2,
        MODE_STOP   = 2'd3
    } mode_t;

    // sticky out-of-bounds side
    typedef enum logic [1:0]
    {
        SIDE_NONE  = 2'd0,
        SIDE_LEFT  = 2'd1,
        SIDE_RIGHT = 2'd2,
        SIDE_SPARE = 2'd3
    } side_t;

    // register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_RIGHT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_LEFT    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DUTY_FLOOR   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_DUTY_CEILING = 3'd6;

    // register reset values
    localparam logic [15:0] PROP_GAIN_RST    = 16'd256;
    localparam logic [15:0] DERIV_GAIN_RST   = 16'd0;
    localparam logic [7:0]  CENTER_X_RST     = 8'd80;
    localparam logic [11:0] BASE_RIGHT_RST   = 12'd1550;
    localparam logic [11:0] BASE_LEFT_RST    = 12'd1350;
    localparam logic [11:0] DUTY_FLOOR_RST   = 12'd1300;
    localparam logic [11:0] DUTY_CEILING_RST = 12'd1600;

    // classification thresholds
    localparam logic [7:0] EDGE_LOW      = 8'd50;
    localparam logic [7:0] EDGE_HIGH     = 8'd110;
    localparam logic [7:0] SIZE_STOP_MIN = 8'd3;
    localparam logic [7:0] SIZE_STOP_MAX = 8'd12;

    // fixed duties
    localparam logic [11:0] SEEK_RIGHT_DUTY = 12'd1400;
    localparam logic [11:0] SEEK_LEFT_DUTY  = 12'd1500;
    localparam logic [11:0] STOP_DUTY       = 12'd0;

    // queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // configuration registers
    typedef struct packed
    {
        logic signed [15:0] prop_gain;
        logic signed [15:0] deriv_gain;
        logic [7:0]         center_x;
        logic [11:0]        base_right;
        logic [11:0]        base_left;
        logic [11:0]        duty_floor;
        logic [11:0]        duty_ceiling;
    } cfg_t;

    // classified frame handed from front to back
    typedef struct packed
    {
        mode_t             mode;
        logic              led_off;
        logic              beep_enable;
        logic signed [8:0] cur_error;
        logic signed [8:0] prev_error;
    } cmd_t;

endpackage

[hdl/ttdc_front.sv]
// ttdc_front: accepts camera words, tracks edge side, mode and error
// depends on ttdc_pkg
`timescale 1ns / 1ps

module ttdc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  ttdc_pkg::cfg_t      cfg,
    input  logic                frame_valid,
    output logic                frame_stall,
    input  logic [7:0]          target_x,
    input  logic [7:0]          target_width,
    input  logic [7:0]          target_size,
    input  logic                menu_switch,
    input  logic                beep_switch,
    input  logic                queue_full,
    output logic                push,
    output ttdc_pkg::cmd_t      push_cmd
);
    import ttdc_pkg::*;

    side_t             edge_side_reg;
    side_t             edge_side_next;
    mode_t             mode_reg;
    mode_t             mode_next;
    logic signed [8:0] cur_error_reg;
    logic signed [8:0] cur_error_next;
    logic              x_seen;
    logic              size_stop;
    logic              nothing_seen;

    // accept whenever the queue has room
    assign frame_stall = queue_full;
    assign push        = frame_valid && !queue_full;

    // side, mode and error of the incoming word
    always_comb
    begin
        x_seen       = (target_x != 8'd0);
        size_stop    = target_size inside {[SIZE_STOP_MIN:SIZE_STOP_MAX]};
        nothing_seen = (target_width == 8'd0) && (target_size == 8'd0);

        edge_side_next = edge_side_reg;
        if (x_seen && (target_x < EDGE_LOW))
        begin
            edge_side_next = SIDE_LEFT;
        end
        else if (x_seen && (target_x > EDGE_HIGH))
        begin
            edge_side_next = SIDE_RIGHT;
        end

        mode_next = mode_reg;
        if ((edge_side_next == SIDE_LEFT) && nothing_seen)
        begin
            mode_next = MODE_SEEK_L;
        end
        else if ((edge_side_next == SIDE_RIGHT) && nothing_seen)
        begin
            mode_next = MODE_SEEK_R;
        end
        else if (x_seen && (target_width != 8'd0) && (target_size != 8'd0))
        begin
            mode_next = MODE_RUN;
        end
        if (size_stop || !menu_switch)
        begin
            mode_next = MODE_STOP;
        end

        cur_error_next = $signed({1'b0, target_x}) - $signed({1'b0, cfg.center_x});

        push_cmd.mode        = mode_next;
        push_cmd.led_off     = !size_stop;
        push_cmd.beep_enable = beep_switch;
        push_cmd.cur_error   = cur_error_next;
        push_cmd.prev_error  = cur_error_reg;
    end

    // tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_side_reg <= SIDE_NONE;
            mode_reg      <= MODE_STOP;
            cur_error_reg <= 9'sd0;
        end
        else if (push)
        begin
            edge_side_reg <= edge_side_next;
            mode_reg      <= mode_next;
            cur_error_reg <= cur_error_next;
        end
    end

endmodule

[hdl/ttdc_queue.sv]
// ttdc_queue: short queue of classified frames between front and back
// depends on ttdc_pkg
`timescale 1ns / 1ps

module ttdc_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ttdc_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output ttdc_pkg::cmd_t head_cmd
);
    import ttdc_pkg::*;

    cmd_t                   slots_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = slots_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[hdl/ttdc_back.sv]
// ttdc_back: PD steering term, duty clamp and mode selection in three stages
// depends on ttdc_pkg
`timescale 1ns / 1ps

module ttdc_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  ttdc_pkg::cfg_t cfg,
    input  logic           queue_not_empty,
    input  ttdc_pkg::cmd_t head_cmd,
    output logic           pop,
    output logic           result_valid,
    input  logic           result_stall,
    output logic [1:0]     drive_mode,
    output logic [11:0]    right_duty,
    output logic [11:0]    left_duty,
    output logic           led_off,
    output logic           beep_enable
);
    import ttdc_pkg::*;

    // stage ready chain
    logic out_ready;
    logic s2_ready;
    logic s1_ready;

    // stage 1: products
    logic               s1_valid_reg;
    cmd_t               s1_cmd_reg;
    logic signed [24:0] s1_p_reg;
    logic signed [25:0] s1_d_reg;
    logic signed [9:0]  err_diff;
    logic signed [24:0] p_prod;
    logic signed [25:0] d_prod;
    logic signed [15:0] kp;
    logic signed [15:0] kd;
    logic signed [8:0]  cur_err;

    // stage 2: scaled and saturated steering term
    logic               s2_valid_reg;
    cmd_t               s2_cmd_reg;
    logic signed [15:0] s2_steer_reg;
    logic signed [26:0] pd_sum;
    logic signed [26:0] pd_biased;
    logic signed [18:0] pd_quot;
    logic signed [15:0] steer_sat;

    // stage 3: output word
    logic               out_valid_reg;
    logic [1:0]         mode_out_reg;
    logic [11:0]        right_out_reg;
    logic [11:0]        left_out_reg;
    logic               led_out_reg;
    logic               beep_out_reg;
    logic signed [17:0] right_raw;
    logic signed [17:0] left_raw;
    logic [11:0]        right_clamped;
    logic [11:0]        left_clamped;
    logic [11:0]        right_sel;
    logic [11:0]        left_sel;

    assign out_ready = !out_valid_reg || !result_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign pop       = queue_not_empty && s1_ready;

    // gain products
    always_comb
    begin
        kp       = cfg.prop_gain;
        kd       = cfg.deriv_gain;
        cur_err  = head_cmd.cur_error;
        err_diff = 10'(head_cmd.prev_error) - 10'(cur_err);
        p_prod   = 25'(kp) * 25'(cur_err);
        d_prod   = 26'(kd) * 26'(err_diff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_cmd_reg <= head_cmd;
            s1_p_reg   <= p_prod;
            s1_d_reg   <= d_prod;
        end
    end

    // sum, divide by 256 toward zero, saturate to 16 bits
    always_comb
    begin
        pd_sum    = 27'(s1_p_reg) - 27'(s1_d_reg);
        pd_biased = pd_sum + (pd_sum[26] ? 27'sd255 : 27'sd0);
        pd_quot   = pd_biased[26:8];
        if (pd_quot > 19'sd32767)
        begin
            steer_sat = 16'sh7fff;
        end
        else if (pd_quot < -19'sd32768)
        begin
            steer_sat = 16'sh8000;
        end
        else
        begin
            steer_sat = pd_quot[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_cmd_reg   <= s1_cmd_reg;
            s2_steer_reg <= steer_sat;
        end
    end

    // wheel duties, both clamped to the shared floor and ceiling, ceiling winning
    always_comb
    begin
        right_raw = $signed({6'b0, cfg.base_right}) - 18'(s2_steer_reg);
        left_raw  = $signed({6'b0, cfg.base_left}) - 18'(s2_steer_reg);

        right_clamped = right_raw[11:0];
        if (right_raw < $signed({6'b0, cfg.duty_floor}))
        begin
            right_clamped = cfg.duty_floor;
        end
        if ((right_raw > $signed({6'b0, cfg.duty_ceiling}))
            || (cfg.duty_floor > cfg.duty_ceiling))
        begin
            right_clamped = cfg.duty_ceiling;
        end

        left_clamped = left_raw[11:0];
        if (left_raw < $signed({6'b0, cfg.duty_floor}))
        begin
            left_clamped = cfg.duty_floor;
        end
        if ((left_raw > $signed({6'b0, cfg.duty_ceiling}))
            || (cfg.duty_floor > cfg.duty_ceiling))
        begin
            left_clamped = cfg.duty_ceiling;
        end

        case (s2_cmd_reg.mode)
            MODE_RUN:
            begin
                right_sel = right_clamped;
                left_sel  = left_clamped;
            end
            MODE_SEEK_R:
            begin
                right_sel = SEEK_RIGHT_DUTY;
                left_sel  = SEEK_RIGHT_DUTY;
            end
            MODE_SEEK_L:
            begin
                right_sel = SEEK_LEFT_DUTY;
                left_sel  = SEEK_LEFT_DUTY;
            end
            default:
            begin
                right_sel = STOP_DUTY;
                left_sel  = STOP_DUTY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s2_valid_reg)
        begin
            mode_out_reg  <= s2_cmd_reg.mode;
            right_out_reg <= right_sel;
            left_out_reg  <= left_sel;
            led_out_reg   <= s2_cmd_reg.led_off;
            beep_out_reg  <= s2_cmd_reg.beep_enable;
        end
    end

    assign result_valid = out_valid_reg;
    assign drive_mode   = mode_out_reg;
    assign right_duty   = right_out_reg;
    assign left_duty    = left_out_reg;
    assign led_off      = led_out_reg;
    assign beep_enable  = beep_out_reg;

endmodule

[hdl/target_tracking_drive_controller_core.sv]
// channel   handshake                     payload
// frame     frame_valid / frame_stall     target_x, target_width, target_size,
//                                         menu_switch, beep_switch
// result    result_valid / result_stall   drive_mode, right_duty, left_duty,
//                                         led_off, beep_enable
// config    cfg_write                     cfg_index, cfg_data
//
// one word per cycle while results are not stalled; a taken frame passes the
// queue slot, product stage, scale/saturate stage and output register in turn
// the front takes a frame whenever the two-entry queue has room
// a stalled result holds the back stages; the front keeps taking words
// until the queue fills
// reset clears tracking state, queue and stage valids, and loads the
// register defaults
`timescale 1ns / 1ps

module target_tracking_drive_controller_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [ttdc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ttdc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 frame_valid,
    output logic                                 frame_stall,
    input  logic [7:0]                           target_x,
    input  logic [7:0]                           target_width,
    input  logic [7:0]                           target_size,
    input  logic                                 menu_switch,
    input  logic                                 beep_switch,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [1:0]                           drive_mode,
    output logic [11:0]                          right_duty,
    output logic [11:0]                          left_duty,
    output logic                                 led_off,
    output logic                                 beep_enable
);
    import ttdc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic push;
    cmd_t push_cmd;
    logic queue_full;
    logic pop;
    logic queue_not_empty;
    cmd_t head_cmd;

    // register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_PROP_GAIN:    cfg_next.prop_gain    = cfg_data[15:0];
                REG_DERIV_GAIN:   cfg_next.deriv_gain   = cfg_data[15:0];
                REG_CENTER_X:     cfg_next.center_x     = cfg_data[7:0];
                REG_BASE_RIGHT:   cfg_next.base_right   = cfg_data[11:0];
                REG_BASE_LEFT:    cfg_next.base_left    = cfg_data[11:0];
                REG_DUTY_FLOOR:   cfg_next.duty_floor   = cfg_data[11:0];
                REG_DUTY_CEILING: cfg_next.duty_ceiling = cfg_data[11:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain    <= PROP_GAIN_RST;
            cfg_reg.deriv_gain   <= DERIV_GAIN_RST;
            cfg_reg.center_x     <= CENTER_X_RST;
            cfg_reg.base_right   <= BASE_RIGHT_RST;
            cfg_reg.base_left    <= BASE_LEFT_RST;
            cfg_reg.duty_floor   <= DUTY_FLOOR_RST;
            cfg_reg.duty_ceiling <= DUTY_CEILING_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // classification front
    ttdc_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .target_x     (target_x),
        .target_width (target_width),
        .target_size  (target_size),
        .menu_switch  (menu_switch),
        .beep_switch  (beep_switch),
        .queue_full   (queue_full),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    // decoupling queue
    ttdc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .head_cmd  (head_cmd)
    );

    // steering and duty back end
    ttdc_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .queue_not_empty (queue_not_empty),
        .head_cmd        (head_cmd),
        .pop             (pop),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .drive_mode      (drive_mode),
        .right_duty      (right_duty),
        .left_duty       (left_duty),
        .led_off         (led_off),
        .beep_enable     (beep_enable)
    );

endmodule

[verif/target_tracking_drive_controller_core_tb.sv]
// target_tracking_drive_controller_core_tb: self-checking bench for the drive controller core
// holds its own predictor of mode, duties, led and beeper; depends on ttdc_pkg and the core
`timescale 1ns / 1ps

module target_tracking_drive_controller_core_tb;

    import ttdc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_FRAMES  = 245;
    localparam int HOLD_CYCLES   = 64;
    localparam int TAIL_CYCLES   = 10;

    // one camera frame word
    typedef struct
    {
        logic [7:0] x;
        logic [7:0] w;
        logic [7:0] s;
        logic       menu;
        logic       beep;
    } frame_word_t;

    // one drive result word
    typedef struct
    {
        mode_t       mode;
        logic [11:0] right;
        logic [11:0] left;
        logic        led;
        logic        beep;
    } drive_word_t;

    // directed stimulus row, with an optional typed-in result
    typedef struct
    {
        frame_word_t f;
        bit          typed;
        drive_word_t d;
    } frame_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   frame_valid;
    logic                   frame_stall;
    logic [7:0]             target_x;
    logic [7:0]             target_width;
    logic [7:0]             target_size;
    logic                   menu_switch;
    logic                   beep_switch;
    logic                   result_valid;
    logic                   result_stall;
    logic [1:0]             drive_mode;
    logic [11:0]            right_duty;
    logic [11:0]            left_duty;
    logic                   led_off;
    logic                   beep_enable;

    // predictor copy of the registers
    logic signed [15:0] c_prop;
    logic signed [15:0] c_deriv;
    logic [7:0]         c_center;
    logic [11:0]        c_base_r;
    logic [11:0]        c_base_l;
    logic [11:0]        c_floor;
    logic [11:0]        c_ceil;

    // predictor copy of the tracking state
    side_t trk_side;
    mode_t trk_mode;
    int    err_prev;
    int    err_cur;

    drive_word_t drive_q[$];
    frame_row_t  dir_rows[$];
    int          mismatch_cnt;
    int          cycle_cnt;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_req;

    target_tracking_drive_controller_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .target_x     (target_x),
        .target_width (target_width),
        .target_size  (target_size),
        .menu_switch  (menu_switch),
        .beep_switch  (beep_switch),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .drive_mode   (drive_mode),
        .right_duty   (right_duty),
        .left_duty    (left_duty),
        .led_off      (led_off),
        .beep_enable  (beep_enable)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run-window clamp, ceiling wins over floor
    function automatic logic [11:0] clamp_duty(longint duty);
        if (duty < longint'(c_floor))
            duty = longint'(c_floor);
        if (duty > longint'(c_ceil))
            duty = longint'(c_ceil);
        return duty[11:0];
    endfunction

    // advance the tracking state by one frame and return the drive word
    function automatic drive_word_t track_frame(frame_word_t f);
        drive_word_t d;
        longint      pd_sum;
        longint      steer;
        d.led  = 1'b1;
        d.beep = f.beep;

        // sticky side
        if (f.x != 8'd0 && f.x < EDGE_LOW)
            trk_side = SIDE_LEFT;
        else if (f.x > EDGE_HIGH)
            trk_side = SIDE_RIGHT;

        // mode rules, then the forced stops
        if (trk_side == SIDE_LEFT && f.w == 8'd0 && f.s == 8'd0)
            trk_mode = MODE_SEEK_L;
        else if (trk_side == SIDE_RIGHT && f.w == 8'd0 && f.s == 8'd0)
            trk_mode = MODE_SEEK_R;
        else if (f.x != 8'd0 && f.w != 8'd0 && f.s != 8'd0)
            trk_mode = MODE_RUN;
        if (f.s >= SIZE_STOP_MIN && f.s <= SIZE_STOP_MAX)
        begin
            d.led    = 1'b0;
            trk_mode = MODE_STOP;
        end
        if (!f.menu)
            trk_mode = MODE_STOP;

        // pd steer term, truncated toward zero and saturated
        err_prev = err_cur;
        err_cur  = int'(f.x) - int'(c_center);
        pd_sum   = longint'(c_prop) * longint'(err_cur)
                 - longint'(c_deriv) * longint'(err_prev - err_cur);
        steer    = pd_sum / 256;
        if (steer > 32767)
            steer = 32767;
        if (steer < -32768)
            steer = -32768;

        d.mode = trk_mode;
        case (trk_mode)
            MODE_RUN:
            begin
                d.right = clamp_duty(longint'(c_base_r) - steer);
                d.left  = clamp_duty(longint'(c_base_l) - steer);
            end
            MODE_SEEK_R:
            begin
                d.right = SEEK_RIGHT_DUTY;
                d.left  = SEEK_RIGHT_DUTY;
            end
            MODE_SEEK_L:
            begin
                d.right = SEEK_LEFT_DUTY;
                d.left  = SEEK_LEFT_DUTY;
            end
            default:
            begin
                d.right = STOP_DUTY;
                d.left  = STOP_DUTY;
            end
        endcase
        return d;
    endfunction

    // one mismatch line and count
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    // compare an accepted result word with the oldest expected one
    task automatic check_result();
        drive_word_t want;
        if (drive_q.size() == 0)
        begin
            report_mismatch($sformatf("result word with none expected, mode %0d", drive_mode));
            return;
        end
        want = drive_q.pop_front();
        if (drive_mode !== want.mode)
            report_mismatch($sformatf("drive_mode got %0d expected %0d", drive_mode, want.mode));
        if (right_duty !== want.right)
            report_mismatch($sformatf("right_duty got %0d expected %0d", right_duty, want.right));
        if (left_duty !== want.left)
            report_mismatch($sformatf("left_duty got %0d expected %0d", left_duty, want.left));
        if (led_off !== want.led)
            report_mismatch($sformatf("led_off got %0d expected %0d", led_off, want.led));
        if (beep_enable !== want.beep)
            report_mismatch($sformatf("beep_enable got %0d expected %0d", beep_enable,
                want.beep));
    endtask

    // offer one frame word and wait until it is taken
    task automatic put_frame(input frame_word_t f);
        while ($urandom_range(99) < send_idle_pct)
        begin
            frame_valid <= 1'b0;
            @(posedge clk);
        end
        frame_valid  <= 1'b1;
        target_x     <= f.x;
        target_width <= f.w;
        target_size  <= f.s;
        menu_switch  <= f.menu;
        beep_switch  <= f.beep;
        @(posedge clk);
        while (frame_stall)
            @(posedge clk);
    endtask

    // drop valid and wait for every expected word
    task automatic settle();
        frame_valid <= 1'b0;
        while (drive_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // one register write, enable left high for the caller to lower
    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_PROP_GAIN:    c_prop   = val;
            REG_DERIV_GAIN:   c_deriv  = val;
            REG_CENTER_X:     c_center = val[7:0];
            REG_BASE_RIGHT:   c_base_r = val[11:0];
            REG_BASE_LEFT:    c_base_l = val[11:0];
            REG_DUTY_FLOOR:   c_floor  = val[11:0];
            REG_DUTY_CEILING: c_ceil   = val[11:0];
            default:          ;
        endcase
    endtask

    // write the whole register set
    task automatic load_config(input logic [15:0] prop, input logic [15:0] deriv,
                               input logic [15:0] center, input logic [15:0] base_r,
                               input logic [15:0] base_l, input logic [15:0] floor_v,
                               input logic [15:0] ceil_v);
        put_reg(REG_PROP_GAIN, prop);
        put_reg(REG_DERIV_GAIN, deriv);
        put_reg(REG_CENTER_X, center);
        put_reg(REG_BASE_RIGHT, base_r);
        put_reg(REG_BASE_LEFT, base_l);
        put_reg(REG_DUTY_FLOOR, floor_v);
        put_reg(REG_DUTY_CEILING, ceil_v);
        cfg_write <= 1'b0;
    endtask

    // directed row builder
    task automatic add_row(input int x, input int w, input int s, input int menu, input int beep,
                           input int typed, input mode_t mode, input int duty, input int led);
        frame_row_t r;
        r.f.x     = 8'(x);
        r.f.w     = 8'(w);
        r.f.s     = 8'(s);
        r.f.menu  = 1'(menu);
        r.f.beep  = 1'(beep);
        r.typed   = 1'(typed);
        r.d.mode  = mode;
        r.d.right = 12'(duty);
        r.d.left  = 12'(duty);
        r.d.led   = 1'(led);
        r.d.beep  = 1'(beep);
        dir_rows.push_back(r);
    endtask

    // random frame: mostly tracking and lost-target sequences, some noise
    function automatic frame_word_t gen_frame();
        frame_word_t f;
        int          pick;
        pick   = $urandom_range(99);
        f.x    = 8'($urandom);
        f.w    = 8'($urandom);
        f.s    = 8'($urandom);
        f.menu = ($urandom_range(99) < 95);
        f.beep = 1'($urandom);
        if (pick < 55)
        begin
            // target in view, size outside the stop window
            f.x = 8'($urandom_range(1, 255));
            f.w = 8'($urandom_range(1, 255));
            f.s = ($urandom_range(9) == 0) ? 8'($urandom_range(1, 2))
                                           : 8'($urandom_range(13, 255));
        end
        else if (pick < 72)
        begin
            // target lost, column says where it went
            case ($urandom_range(3))
                0:       f.x = 8'($urandom_range(1, 49));
                1:       f.x = 8'($urandom_range(111, 255));
                2:       f.x = 8'd0;
                default: f.x = 8'($urandom_range(50, 110));
            endcase
            f.w = 8'd0;
            f.s = 8'd0;
        end
        else if (pick < 82)
        begin
            f.s = 8'($urandom_range(3, 12));
        end
        else
        begin
            f.menu = 1'($urandom);
        end
        return f;
    endfunction

    // watchdog
    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: check accepted words, then choose the next stall
    initial
    begin : result_side
        int hold_left;
        hold_left    = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
                check_result();
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // frame side and phases
    initial
    begin : stimulus
        frame_word_t f;
        drive_word_t d;
        mismatch_cnt  = 0;
        hold_req      = 1'b0;
        send_idle_pct = 27;
        recv_idle_pct = 52;
        rst_n         <= 1'b0;
        cfg_write     <= 1'b0;
        cfg_index     <= REG_PROP_GAIN;
        cfg_data      <= '0;
        frame_valid   <= 1'b0;
        target_x      <= '0;
        target_width  <= '0;
        target_size   <= '0;
        menu_switch   <= 1'b0;
        beep_switch   <= 1'b0;

        // predictor reset state
        c_prop   = PROP_GAIN_RST;
        c_deriv  = DERIV_GAIN_RST;
        c_center = CENTER_X_RST;
        c_base_r = BASE_RIGHT_RST;
        c_base_l = BASE_LEFT_RST;
        c_floor  = DUTY_FLOOR_RST;
        c_ceil   = DUTY_CEILING_RST;
        trk_side = SIDE_NONE;
        trk_mode = MODE_STOP;
        err_prev = 0;
        err_cur  = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, reset register values
        add_row(0,   0,   0,   1, 1, 1, MODE_STOP,   0,    1);
        add_row(100, 10,  20,  1, 1, 0, MODE_RUN,    0,    1);
        add_row(49,  0,   0,   1, 1, 1, MODE_SEEK_L, 1500, 1);
        add_row(0,   0,   0,   1, 0, 1, MODE_SEEK_L, 1500, 1);
        add_row(111, 0,   0,   1, 1, 1, MODE_SEEK_R, 1400, 1);
        add_row(50,  0,   0,   1, 1, 1, MODE_SEEK_R, 1400, 1);
        add_row(110, 5,   0,   1, 1, 0, MODE_RUN,    0,    1);
        add_row(255, 255, 255, 1, 0, 0, MODE_RUN,    0,    1);
        add_row(1,   1,   1,   1, 1, 0, MODE_RUN,    0,    1);
        add_row(0,   0,   0,   1, 1, 1, MODE_SEEK_L, 1500, 1);
        add_row(80,  1,   3,   1, 1, 1, MODE_STOP,   0,    0);
        add_row(80,  1,   12,  1, 1, 1, MODE_STOP,   0,    0);
        add_row(80,  1,   13,  1, 1, 0, MODE_RUN,    0,    1);
        add_row(30,  200, 2,   1, 1, 0, MODE_RUN,    0,    1);
        add_row(0,   5,   20,  1, 1, 0, MODE_RUN,    0,    1);
        add_row(100, 10,  20,  0, 1, 1, MODE_STOP,   0,    1);
        add_row(100, 10,  5,   0, 0, 1, MODE_STOP,   0,    0);
        add_row(0,   10,  10,  1, 1, 1, MODE_STOP,   0,    0);
        add_row(0,   0,   0,   1, 1, 1, MODE_SEEK_L, 1500, 1);
        add_row(200, 90,  40,  1, 1, 0, MODE_RUN,    0,    1);
        add_row(60,  90,  40,  1, 1, 0, MODE_RUN,    0,    1);
        foreach (dir_rows[i])
        begin
            put_frame(dir_rows[i].f);
            d = track_frame(dir_rows[i].f);
            drive_q.push_back(dir_rows[i].typed ? dir_rows[i].d : d);
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            if (ph > 0)
            begin
                settle();
                case (ph)
                    1: load_config(16'h7FFF, 16'h8000, 16'd0, 16'd4095, 16'd0, 16'd0, 16'd4095);
                    2: load_config(16'h8000, 16'h7FFF, 16'd255, 16'd0, 16'd4095, 16'd4095, 16'd0);
                    6: load_config(16'($urandom_range(0, 2047) - 1024),
                                   16'($urandom_range(0, 2047) - 1024),
                                   16'($urandom_range(40, 120)), 16'($urandom_range(1000, 2000)),
                                   16'($urandom_range(1000, 2000)), 16'($urandom_range(0, 1500)),
                                   16'($urandom_range(1500, 4095)));
                    7: load_config(PROP_GAIN_RST, DERIV_GAIN_RST, 16'(CENTER_X_RST),
                                   16'(BASE_RIGHT_RST), 16'(BASE_LEFT_RST),
                                   16'(DUTY_FLOOR_RST), 16'(DUTY_CEILING_RST));
                    default: load_config(16'($urandom), 16'($urandom), 16'($urandom),
                                         16'($urandom), 16'($urandom), 16'($urandom),
                                         16'($urandom));
                endcase
            end

            // idling regime by phase
            if (ph < 3)
            begin
                send_idle_pct = 27;
                recv_idle_pct = 52;
            end
            else if (ph < 6)
            begin
                send_idle_pct = 52;
                recv_idle_pct = 27;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // long receiver hold-off so the queue fills and stalls frames
            if (ph == 6)
                hold_req = 1'b1;

            for (int n = 0; n < PHASE_FRAMES; n++)
            begin
                f = gen_frame();
                put_frame(f);
                drive_q.push_back(track_frame(f));
            end
        end

        settle();
        if (mismatch_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
